// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate function of the stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Command from controller to datapath.
  typedef struct packed {
    logic       load_byte;   // write byte_sel into block buffer
    logic [1:0] byte_sel;    // 0 input, 1 pad 0x80, 2 zero, 3 length byte
    logic       start;       // copy hash to round vars, start round counter
    logic       round;       // run one round
    logic       update;      // add round vars into hash
    logic       reinit;      // restore initial hash, clear counters
    logic       count_msg;   // count one message byte
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;        // bytes in block
    logic       last_round;  // round 63 active
  } sha_sts_t;

  localparam logic [1:0] SEL_IN   = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_stream_hasher_core.sv =====
// Operation: a data byte is written into the block; a byte that fills the block starts
// compression (load, 64 rounds at one per cycle, hash update).
// Input bytes are not accepted while a block is being compressed.
// Finish: padding bytes at one per cycle plus one compression per block
// (one or two), then eight digest transfers.
// Reset (async, active low) restores the initial hash and clears the byte counts.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-stream SHA-256 with digest output as eight 32-bit words.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero
  output logic        m_axis_tlast
);
  import sha256_pkg::*;

  sha_cmd_t   cmd;
  sha_sts_t   sts;
  logic [2:0] word_sel;
  logic [31:0] hword;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .word_sel_o (word_sel),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .byte_i     (s_axis_tdata),
    .word_sel_i (word_sel),
    .sts_o      (sts),
    .hash_word_o(hword)
  );

  assign m_axis_tdata = {5'd0, word_sel, hword};
  assign m_axis_tlast = (word_sel == 3'd7);

endmodule

// ===== rtl/sha256_dp.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Message schedule window (also the byte buffer), round unit, hash state.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sha256_pkg::sha_cmd_t cmd_i,
  input  logic [7:0]           byte_i,
  input  logic [2:0]           word_sel_i,
  output sha256_pkg::sha_sts_t sts_o,
  output logic [31:0]          hash_word_o
);
  import sha256_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q;
  logic [60:0] msg_q;
  logic [5:0]  rnd_q;
  logic [7:0]  wr_byte;
  logic [63:0] bitlen;
  logic [31:0] w_cur, w15, w2, s0w, s1w, w_new;
  logic [31:0] s1, ch, t1, s0, mj;

  assign bitlen = {msg_q, 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      SEL_IN:   wr_byte = byte_i;
      SEL_PAD:  wr_byte = 8'h80;
      SEL_ZERO: wr_byte = 8'h00;
      default:  wr_byte = bitlen[{~fill_q[2:0], 3'b000} +: 8];
    endcase
  end

  assign w15   = w_q[1];
  assign w2    = w_q[14];
  assign s0w   = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1w   = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign w_new = w_q[0] + s0w + w_q[9] + s1w;
  assign w_cur = w_q[0];

  assign s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
  assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1 = v_q[7] + s1 + ch + ROUND_K[rnd_q] + w_cur;
  assign s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
  assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.round) begin
      // window shifts so w_q[0] is always the current schedule word
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= (rnd_q < 6'd48) ? w_new : w_q[0];
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + s0 + mj;
    end else if (cmd_i.load_byte) begin
      // bytes land big-endian straight into the schedule words
      w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
      fill_q <= '0;
      msg_q  <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
        fill_q <= '0;
        msg_q  <= '0;
      end else begin
        if (cmd_i.update) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
        end
        if (cmd_i.load_byte) fill_q <= fill_q + 6'd1;
        if (cmd_i.count_msg) msg_q <= msg_q + 61'd1;
      end
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
    end
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.last_round = (rnd_q == 6'd63);
  assign hash_word_o      = h_q[word_sel_i];

endmodule

// ===== rtl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           word_sel_o,
  input  sha256_pkg::sha_sts_t sts_i,
  output sha256_pkg::sha_cmd_t cmd_o
);
  import sha256_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_PAD0  = 8'b00000010,
    ST_PADZ  = 8'b00000100,
    ST_LEN   = 8'b00001000,
    ST_START = 8'b00010000,
    ST_ROUND = 8'b00100000,
    ST_UPD   = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_e;

  state_e     state_q, state_d;
  logic       fin_q, fin_d;    // finishing the message
  logic       lenw_q, lenw_d;  // length bytes written, next compress is final
  logic [2:0] word_q, word_d;

  assign word_sel_o  = word_q;
  assign out_valid_o = (state_q == ST_OUT);
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    lenw_d  = lenw_q;
    word_d  = word_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_kind_i == KIND_DATA) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.byte_sel  = SEL_IN;
            cmd_o.count_msg = 1'b1;
            if (sts_i.fill == 6'd63) state_d = ST_START;
          end else begin
            fin_d   = 1'b1;
            lenw_d  = 1'b0;
            state_d = ST_PAD0;
          end
        end
      end
      ST_PAD0: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = SEL_PAD;
        if (sts_i.fill == 6'd63) state_d = ST_START;
        else if (sts_i.fill == 6'd55) state_d = ST_LEN;
        else state_d = ST_PADZ;
      end
      ST_PADZ: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = SEL_ZERO;
        if (sts_i.fill == 6'd63) state_d = ST_START;
        else if (sts_i.fill == 6'd55) state_d = ST_LEN;
      end
      ST_LEN: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = SEL_LEN;
        if (sts_i.fill == 6'd63) begin
          lenw_d  = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        if (!fin_q) state_d = ST_IDLE;
        else if (lenw_q) begin
          word_d  = '0;
          state_d = ST_OUT;
        end else state_d = ST_PADZ;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          word_d = word_q + 3'd1;
          if (word_q == 3'd7) begin
            cmd_o.reinit = 1'b1;
            fin_d        = 1'b0;
            lenw_d       = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      lenw_q  <= 1'b0;
      word_q  <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      lenw_q  <= lenw_d;
      word_q  <= word_d;
    end
  end

endmodule

// ===== rtl/sha256_chk.sv =====
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during digest");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("word index skip");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("payload changed while stalled");
endmodule

bind sha256_stream_hasher_core sha256_chk u_chk (.*);
